FILE: design/wmm_pkg.sv
// ----------------------------------------------------------------------------
// wmm_pkg - shared types and constants for the min/max morphology block
// Field widths, register codes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wmm_pkg;

  // Fixed field widths of the request and result items
  localparam int unsigned CH_W    = 16;
  localparam int unsigned COORD_W = 7;
  localparam int unsigned DIM_W   = 8;
  localparam int unsigned RAD_W   = 3;
  localparam int unsigned SPAN_W  = RAD_W + 1;
  localparam int unsigned CNT_W   = $clog2(COORD_W);
  localparam int unsigned NUM_CH  = 6;

  // Configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_FILTER_MODE   = 2'd0;
  localparam logic [1:0] REG_KERNEL_RADIUS = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(1);
  localparam logic [DIM_W-1:0] DIM_RST    = DIM_W'(128);

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } mode_e;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_FILTER = 1'b1
  } req_e;

  typedef logic [CH_W-1:0] chan_t;
  // index 0 red, 1 green, 2 blue, 3 alpha, 4 height, 5 roughness
  typedef chan_t [NUM_CH-1:0] pix_t;

  typedef struct packed {
    mode_e            mode;
    logic [RAD_W-1:0] radius;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic store;   // write the accepted pixel into the frame store
    logic latch;   // capture a filter request and its settings
    logic reduce;  // one step of the centre remainder
    logic setup;   // compute window start, clear accumulators
    logic walk;    // read one window pixel and advance
    logic finish;  // move accumulators to the result register
  } cmd_t;

  typedef struct packed {
    logic reduce_last;
    logic walk_last;
    logic out_busy;
  } sts_t;

endpackage

FILE: design/wmm_req_if.sv
// ----------------------------------------------------------------------------
// wmm_req_if - request channel
// Valid/ready channel that carries load and filter items.
// ----------------------------------------------------------------------------
interface wmm_req_if import wmm_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [CH_W-1:0]    red_in;
  logic [CH_W-1:0]    green_in;
  logic [CH_W-1:0]    blue_in;
  logic [CH_W-1:0]    alpha_in;
  logic [CH_W-1:0]    height_in;
  logic [CH_W-1:0]    roughness_in;

  modport source (
    output valid, req_type, pos_x, pos_y, red_in, green_in, blue_in,
           alpha_in, height_in, roughness_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, pos_x, pos_y, red_in, green_in, blue_in,
           alpha_in, height_in, roughness_in,
    output ready
  );

endinterface

FILE: design/wmm_rsp_if.sv
// ----------------------------------------------------------------------------
// wmm_rsp_if - result channel
// Valid/ready channel that carries filtered pixels.
// ----------------------------------------------------------------------------
interface wmm_rsp_if import wmm_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic [CH_W-1:0] alpha_out;
  logic [CH_W-1:0] height_out;
  logic [CH_W-1:0] roughness_out;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out, height_out,
           roughness_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out, height_out,
           roughness_out,
    output ready
  );

endinterface

FILE: design/wmm_ctrl.sv
// ----------------------------------------------------------------------------
// wmm_ctrl - sequencer for load and filter items
// Takes items in idle, then steps a filter item through centre reduction,
// window setup, the window walk and the hand-off to the result register.
// ----------------------------------------------------------------------------
module wmm_ctrl import wmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_filter_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && req_filter_i) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (sts_i.reduce_last) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.store  = req_valid_i && !req_filter_i;
        cmd_o.latch  = req_valid_i && req_filter_i;
      end
      ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_FINISH: begin
        cmd_o.finish = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: design/wmm_dpath.sv
// ----------------------------------------------------------------------------
// wmm_dpath - frame store, window walker and min/max accumulators
// Holds the six-channel frame, reduces the filter centre modulo the image
// size, walks the wrapped window one pixel a cycle and keeps the result
// register toward the output channel.
// ----------------------------------------------------------------------------
module wmm_dpath import wmm_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = 128,
  parameter int unsigned MAX_HEIGHT   = 128,
  parameter int unsigned MAX_RADIUS   = 7,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  cfg_t               cfg_i,
  input  logic [COORD_W-1:0] req_x_i,
  input  logic [COORD_W-1:0] req_y_i,
  input  pix_t               req_pix_i,
  input  logic               out_ready_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  output pix_t               out_pix_o
);

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CB     = CHANNEL_BITS;

  // Clamp a configured dimension to 1..limit
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > limit) r = DIM_W'(limit);
    return r;
  endfunction

  // Cap the radius at the hardware limit and one less than the dimension
  function automatic logic [RAD_W-1:0] cap_rad(logic [RAD_W-1:0] r, logic [DIM_W-1:0] dim);
    logic [RAD_W-1:0] c;
    c = (32'(r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r;
    if (DIM_W'(c) > dim - 1'b1) c = RAD_W'(dim - 1'b1);
    return c;
  endfunction

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [DIM_W-1:0]   w_q, h_q;
  logic [RAD_W-1:0]   rx_q, ry_q;
  mode_e              mode_q;
  logic [COORD_W-1:0] xsh_q, ysh_q;
  logic [CNT_W-1:0]   bit_cnt_q;
  logic [DIM_W-1:0]   cx_q, cy_q;
  logic [DIM_W:0]     rem_x, rem_y, start_x, start_y;
  logic [DIM_W-1:0]   sx_q, sy_q, sx0_q;
  logic [SPAN_W-1:0]  dx_q, dy_q;
  logic               last_col, last_row;
  logic [DIM_W-1:0]   sx_inc, sy_inc;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               wr_en;
  logic [4*CB-1:0]    color_mem [DEPTH];
  logic [2*CB-1:0]    surf_mem  [DEPTH];
  logic [4*CB-1:0]    color_wr, color_rd_q;
  logic [2*CB-1:0]    surf_wr, surf_rd_q;
  logic               rd_vld_q;
  logic [CB-1:0]      rd_ch  [NUM_CH];
  logic [CB-1:0]      acc_q  [NUM_CH];
  logic               out_valid_q;
  pix_t               out_pix_q;

  assign w_eff = clamp_dim(cfg_i.width, MAX_WIDTH);
  assign h_eff = clamp_dim(cfg_i.height, MAX_HEIGHT);

  // Capture the request and its settings
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      w_q    <= w_eff;
      h_q    <= h_eff;
      rx_q   <= cap_rad(cfg_i.radius, w_eff);
      ry_q   <= cap_rad(cfg_i.radius, h_eff);
      mode_q <= cfg_i.mode;
    end
  end

  // Centre remainder, one bit of the coordinate per cycle
  assign rem_x = {cx_q, xsh_q[COORD_W-1]};
  assign rem_y = {cy_q, ysh_q[COORD_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      xsh_q     <= req_x_i;
      ysh_q     <= req_y_i;
      cx_q      <= '0;
      cy_q      <= '0;
      bit_cnt_q <= '0;
    end else if (cmd_i.reduce) begin
      xsh_q     <= xsh_q << 1;
      ysh_q     <= ysh_q << 1;
      cx_q      <= (rem_x >= {1'b0, w_q}) ? DIM_W'(rem_x - {1'b0, w_q}) : DIM_W'(rem_x);
      cy_q      <= (rem_y >= {1'b0, h_q}) ? DIM_W'(rem_y - {1'b0, h_q}) : DIM_W'(rem_y);
      bit_cnt_q <= bit_cnt_q + 1'b1;
    end
  end

  assign sts_o.reduce_last = (bit_cnt_q == CNT_W'(COORD_W - 1));

  // Window start, wrapped by one compare and subtract
  assign start_x = {1'b0, cx_q} + {1'b0, w_q} - (DIM_W + 1)'(rx_q);
  assign start_y = {1'b0, cy_q} + {1'b0, h_q} - (DIM_W + 1)'(ry_q);

  // Step to the next column or row with wrap
  assign sx_inc   = ({1'b0, sx_q} + 1'b1 == {1'b0, w_q}) ? '0 : sx_q + 1'b1;
  assign sy_inc   = ({1'b0, sy_q} + 1'b1 == {1'b0, h_q}) ? '0 : sy_q + 1'b1;
  assign last_col = (dx_q == {rx_q, 1'b0});
  assign last_row = (dy_q == {ry_q, 1'b0});

  assign sts_o.walk_last = last_col && last_row;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      sx_q  <= (start_x >= {1'b0, w_q}) ? DIM_W'(start_x - {1'b0, w_q}) : DIM_W'(start_x);
      sx0_q <= (start_x >= {1'b0, w_q}) ? DIM_W'(start_x - {1'b0, w_q}) : DIM_W'(start_x);
      sy_q  <= (start_y >= {1'b0, h_q}) ? DIM_W'(start_y - {1'b0, h_q}) : DIM_W'(start_y);
      dx_q  <= '0;
      dy_q  <= '0;
    end else if (cmd_i.walk) begin
      if (last_col) begin
        dx_q <= '0;
        sx_q <= sx0_q;
        dy_q <= dy_q + 1'b1;
        sy_q <= sy_inc;
      end else begin
        dx_q <= dx_q + 1'b1;
        sx_q <= sx_inc;
      end
    end
  end

  // Frame store addressing
  assign rd_addr = ADDR_W'(32'(sy_q) * 32'(MAX_WIDTH) + 32'(sx_q));
  assign wr_addr = ADDR_W'(32'(req_y_i) * 32'(MAX_WIDTH) + 32'(req_x_i));
  assign wr_en   = cmd_i.store && (32'(req_x_i) < MAX_WIDTH) && (32'(req_y_i) < MAX_HEIGHT);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      color_wr[k*CB +: CB] = CB'(req_pix_i[k]);
    end
    for (int k = 0; k < 2; k++) begin
      surf_wr[k*CB +: CB] = CB'(req_pix_i[k+4]);
    end
  end

  // Frame store: write on load, registered read during the walk
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      color_mem[wr_addr] <= color_wr;
      surf_mem[wr_addr]  <= surf_wr;
    end
    if (cmd_i.walk) begin
      color_rd_q <= color_mem[rd_addr];
      surf_rd_q  <= surf_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.walk;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_ch[k] = color_rd_q[k*CB +: CB];
    end
    for (int k = 0; k < 2; k++) begin
      rd_ch[k+4] = surf_rd_q[k*CB +: CB];
    end
  end

  // Min or max accumulation per channel
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (cmd_i.setup) begin
        acc_q[k] <= (mode_q == MODE_DILATE) ? '0 : '1;
      end else if (rd_vld_q) begin
        if (mode_q == MODE_DILATE) begin
          if (rd_ch[k] > acc_q[k]) acc_q[k] <= rd_ch[k];
        end else begin
          if (rd_ch[k] < acc_q[k]) acc_q[k] <= rd_ch[k];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      for (int k = 0; k < NUM_CH; k++) begin
        out_pix_q[k] <= CH_W'(acc_q[k]);
      end
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_pix_o      = out_pix_q;

endmodule

FILE: design/wraparound_min_max_morphology.sv
// ----------------------------------------------------------------------------
// wraparound_min_max_morphology - six-channel erode/dilate over a frame
// Top level: configuration registers, controller, datapath and the
// request and result channels.
// ----------------------------------------------------------------------------
// A load item writes one pixel into the frame store.
// A filter item returns the per-channel minimum (erode) or maximum (dilate)
// over the square window around the centre, with coordinates wrapped at the
// image size in use. A filter item occupies the block through centre
// reduction modulo the image size, window setup, the window walk and the
// hand-off to the result register: the frame store has a single read
// port and is read one window pixel per cycle, where the window is
// (2*rx+1) by (2*ry+1) pixels and rx and ry are the capped radii. A
// finished result waits in an output register, so loads and the next
// filter item are taken while it is pending. Pixels must be loaded before a
// filter window covers them; the store is not cleared after reset.
// ----------------------------------------------------------------------------
module wraparound_min_max_morphology import wmm_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = 128,
  parameter int unsigned MAX_HEIGHT   = 128,
  parameter int unsigned MAX_RADIUS   = 7,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  wmm_req_if.sink           req_i,
  wmm_rsp_if.source         rsp_o
);

  mode_e            mode_q;
  logic [RAD_W-1:0] radius_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             cfg_we;
  cfg_t             cfg;
  cmd_t             cmd;
  sts_t             sts;
  pix_t             req_pix;
  pix_t             out_pix;

  // Configuration writes
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ERODE;
      radius_q <= RADIUS_RST;
      width_q  <= DIM_RST;
      height_q <= DIM_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_FILTER_MODE:   mode_q   <= mode_e'(pwdata[0]);
        REG_KERNEL_RADIUS: radius_q <= pwdata[RAD_W-1:0];
        REG_IMAGE_WIDTH:   width_q  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  height_q <= pwdata[DIM_W-1:0];
        default:           mode_q   <= mode_q;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_FILTER_MODE:   prdata = APB_DW'(mode_q);
      REG_KERNEL_RADIUS: prdata = APB_DW'(radius_q);
      REG_IMAGE_WIDTH:   prdata = APB_DW'(width_q);
      REG_IMAGE_HEIGHT:  prdata = APB_DW'(height_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg.mode   = mode_q;
  assign cfg.radius = radius_q;
  assign cfg.width  = width_q;
  assign cfg.height = height_q;

  // Request payload
  assign req_pix[0] = req_i.red_in;
  assign req_pix[1] = req_i.green_in;
  assign req_pix[2] = req_i.blue_in;
  assign req_pix[3] = req_i.alpha_in;
  assign req_pix[4] = req_i.height_in;
  assign req_pix[5] = req_i.roughness_in;

  wmm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_filter_i (req_i.req_type == REQ_FILTER),
    .req_ready_o  (req_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  wmm_dpath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_RADIUS   (MAX_RADIUS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .req_x_i     (req_i.pos_x),
    .req_y_i     (req_i.pos_y),
    .req_pix_i   (req_pix),
    .out_ready_i (rsp_o.ready),
    .sts_o       (sts),
    .out_valid_o (rsp_o.valid),
    .out_pix_o   (out_pix)
  );

  // Result payload
  assign rsp_o.red_out       = out_pix[0];
  assign rsp_o.green_out     = out_pix[1];
  assign rsp_o.blue_out      = out_pix[2];
  assign rsp_o.alpha_out     = out_pix[3];
  assign rsp_o.height_out    = out_pix[4];
  assign rsp_o.roughness_out = out_pix[5];

`ifndef SYNTHESIS
  // A filter item makes the block busy in the next cycle
  a_filter_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && (req_i.req_type == REQ_FILTER) |=> !req_i.ready)
    else $error("filter item did not occupy the block");

  // A load item leaves the block free for the next item
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && (req_i.req_type == REQ_LOAD) |=> req_i.ready)
    else $error("load item stalled the request channel");

  // A result appears only at the end of a filter walk
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result raised while the block was idle");
`endif

endmodule
